FILE: hw/rtl/hpn_pkg.sv
// ----------------------------------------------------------------------------
// hpn_pkg
// Shared constants, register codes and types of the Hough peak finder.
// ----------------------------------------------------------------------------
package hpn_pkg;

   localparam int MAX_THETA_BINS = 1024;
   localparam int MAX_RHO_BINS   = 4096;
   localparam int VOTE_BITS      = 16;

   localparam int COL_BITS       = $clog2(MAX_THETA_BINS);
   localparam int ROW_BITS       = $clog2(MAX_RHO_BINS);
   localparam int THETA_REG_BITS = 11;
   localparam int RHO_REG_BITS   = 13;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int LINE_BITS      = 2 * VOTE_BITS;

   localparam int RSP_FIELD_BITS = ROW_BITS + COL_BITS + VOTE_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int REQ_DATA_BITS  = ((VOTE_BITS + 7) / 8) * 8;

   localparam logic [THETA_REG_BITS-1:0] THETA_RESET = THETA_REG_BITS'(180);
   localparam logic [RHO_REG_BITS-1:0]   RHO_RESET   = RHO_REG_BITS'(1024);
   localparam logic [VOTE_BITS-1:0]      VOTES_RESET = VOTE_BITS'(100);
   localparam int MIN_BINS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THETA_BINS = 2'd0,
      CSR_RHO_BINS   = 2'd1,
      CSR_MIN_VOTES  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]  rho;
      logic [COL_BITS-1:0]  theta;
      logic [VOTE_BITS-1:0] votes;
   } peak_type;

   typedef struct packed {
      logic     valid;
      peak_type peak;
   } peak_push_type;

endpackage

FILE: hw/rtl/hpn_line_ram.sv
// ----------------------------------------------------------------------------
// hpn_line_ram
// Line store of the two previous accumulator rows, one word per column with
// the older row in the upper half. One read and one write port, registered
// read data.
// ----------------------------------------------------------------------------
module hpn_line_ram (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [hpn_pkg::COL_BITS-1:0]  rd_addr,
   output logic [hpn_pkg::LINE_BITS-1:0] rd_data,
   input  logic                          wr_en,
   input  logic [hpn_pkg::COL_BITS-1:0]  wr_addr,
   input  logic [hpn_pkg::LINE_BITS-1:0] wr_data
);

   logic [hpn_pkg::LINE_BITS-1:0] mem [hpn_pkg::MAX_THETA_BINS];
   logic [hpn_pkg::LINE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/hpn_window.sv
// ----------------------------------------------------------------------------
// hpn_window
// 3x3 neighborhood register and the peak test on its center cell.
// ----------------------------------------------------------------------------
module hpn_window (
   input  logic                          clock,
   input  logic                          in_valid,
   input  logic [hpn_pkg::VOTE_BITS-1:0] up2,
   input  logic [hpn_pkg::VOTE_BITS-1:0] up1,
   input  logic [hpn_pkg::VOTE_BITS-1:0] vote,
   input  logic [hpn_pkg::COL_BITS-1:0]  col,
   input  logic [hpn_pkg::ROW_BITS-1:0]  row,
   input  logic [hpn_pkg::VOTE_BITS-1:0] min_votes,
   output hpn_pkg::peak_push_type        push
);

   logic [hpn_pkg::VOTE_BITS-1:0] win_ff [3][3];
   logic [hpn_pkg::VOTE_BITS-1:0] win_in [3][3];
   logic [hpn_pkg::VOTE_BITS-1:0] center;
   logic                          greater;
   logic                          interior;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
      end
      win_in[0][2] = up2;
      win_in[1][2] = up1;
      win_in[2][2] = vote;
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         win_ff <= win_in;
      end
   end

   assign center = win_in[1][1];

   always_comb begin
      greater = 1'b0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (win_in[i][j] > center) begin
               greater = 1'b1;
            end
         end
      end
   end

   assign interior = (row >= hpn_pkg::ROW_BITS'(2)) && (col >= hpn_pkg::COL_BITS'(2));

   always_comb begin
      push.valid      = in_valid && interior && !greater && (center >= min_votes);
      push.peak.rho   = row - hpn_pkg::ROW_BITS'(1);
      push.peak.theta = col - hpn_pkg::COL_BITS'(1);
      push.peak.votes = center;
   end

endmodule

FILE: hw/rtl/hpn_out_queue.sv
// ----------------------------------------------------------------------------
// hpn_out_queue
// Two-entry result queue that decouples the window from the response channel.
// ----------------------------------------------------------------------------
module hpn_out_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  hpn_pkg::peak_push_type  push,
   input  logic                    pop,
   output logic                    not_empty,
   output logic [1:0]              count,
   output hpn_pkg::peak_type       head
);

   hpn_pkg::peak_type slot_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push.valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push.valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.peak;
      end
   end

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != 2'd0);
   assign count     = count_ff;

endmodule

FILE: hw/rtl/hough_peak_nms_3x3.sv
// ----------------------------------------------------------------------------
// hough_peak_nms_3x3
// 3x3 non-maximum suppression over a streamed Hough accumulator.
// ----------------------------------------------------------------------------
// Vote counts enter in raster order, one request per cycle, and each interior
// cell that reaches min_votes with no strictly greater neighbor comes out as
// one response, one row and one column behind the input. The line store is read
// at the edge that accepts a request, and the next cycle updates the window,
// compares and writes the column back, so a response enters the response queue
// after its request's s1 stage and can be taken once registered there. Requests are
// taken every cycle; they stall only while held responses (rsp_tready low) and
// the request in flight would fill the two-entry response queue. Border rows and
// columns never respond. Writing theta_bins or rho_bins restarts the accumulator
// at row zero, column zero; sizes are clamped to at least three bins, at most
// 1024 theta bins and at most 4096 rho bins.
module hough_peak_nms_3x3 (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hpn_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // [15:0] vote_count
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hpn_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // rho, theta, votes, pad
   input  logic                                csr_wr_en,
   input  logic [hpn_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [hpn_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   logic [hpn_pkg::THETA_REG_BITS-1:0] theta_ff;
   logic [hpn_pkg::RHO_REG_BITS-1:0]   rho_ff;
   logic [hpn_pkg::VOTE_BITS-1:0]      min_votes_ff;
   logic [hpn_pkg::THETA_REG_BITS-1:0] tb;
   logic [hpn_pkg::RHO_REG_BITS-1:0]   rb;
   logic [hpn_pkg::COL_BITS-1:0]       col_ff;
   logic [hpn_pkg::COL_BITS-1:0]       col_in;
   logic [hpn_pkg::ROW_BITS-1:0]       row_ff;
   logic [hpn_pkg::ROW_BITS-1:0]       row_in;
   logic                               s1_valid_ff;
   logic [hpn_pkg::COL_BITS-1:0]       s1_col_ff;
   logic [hpn_pkg::ROW_BITS-1:0]       s1_row_ff;
   logic [hpn_pkg::VOTE_BITS-1:0]      s1_vote_ff;
   logic [hpn_pkg::LINE_BITS-1:0]      rd_data;
   logic [hpn_pkg::VOTE_BITS-1:0]      up2;
   logic [hpn_pkg::VOTE_BITS-1:0]      up1;
   logic                               accept;
   logic                               pop;
   logic                               size_write;
   logic [1:0]                         count;
   logic [2:0]                         load;
   hpn_pkg::peak_push_type             push;
   hpn_pkg::peak_type                  head;
   hpn_pkg::csr_index_type             csr_code;

   assign csr_code = hpn_pkg::csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         theta_ff     <= hpn_pkg::THETA_RESET;
         rho_ff       <= hpn_pkg::RHO_RESET;
         min_votes_ff <= hpn_pkg::VOTES_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_code)
            hpn_pkg::CSR_THETA_BINS: begin
               theta_ff <= csr_wdata[hpn_pkg::THETA_REG_BITS-1:0];
            end
            hpn_pkg::CSR_RHO_BINS: begin
               rho_ff <= csr_wdata[hpn_pkg::RHO_REG_BITS-1:0];
            end
            hpn_pkg::CSR_MIN_VOTES: begin
               min_votes_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign size_write = csr_wr_en &&
                       ((csr_code == hpn_pkg::CSR_THETA_BINS) ||
                        (csr_code == hpn_pkg::CSR_RHO_BINS));

   always_comb begin
      priority if (theta_ff < hpn_pkg::THETA_REG_BITS'(hpn_pkg::MIN_BINS)) begin
         tb = hpn_pkg::THETA_REG_BITS'(hpn_pkg::MIN_BINS);
      end else if (theta_ff > hpn_pkg::THETA_REG_BITS'(hpn_pkg::MAX_THETA_BINS)) begin
         tb = hpn_pkg::THETA_REG_BITS'(hpn_pkg::MAX_THETA_BINS);
      end else begin
         tb = theta_ff;
      end
      priority if (rho_ff < hpn_pkg::RHO_REG_BITS'(hpn_pkg::MIN_BINS)) begin
         rb = hpn_pkg::RHO_REG_BITS'(hpn_pkg::MIN_BINS);
      end else if (rho_ff > hpn_pkg::RHO_REG_BITS'(hpn_pkg::MAX_RHO_BINS)) begin
         rb = hpn_pkg::RHO_REG_BITS'(hpn_pkg::MAX_RHO_BINS);
      end else begin
         rb = rho_ff;
      end
   end

   // A request needs a queue slot after its s1 stage; the one in flight holds one.
   assign pop        = rsp_tvalid && rsp_tready;
   assign load       = {1'b0, count} + {2'b00, s1_valid_ff};
   assign req_tready = load <= (3'd1 + {2'b00, pop});
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (size_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (({1'b0, col_ff} + hpn_pkg::THETA_REG_BITS'(1)) >= tb) begin
            col_in = '0;
            if (({1'b0, row_ff} + hpn_pkg::RHO_REG_BITS'(1)) >= rb) begin
               row_in = '0;
            end else begin
               row_in = row_ff + hpn_pkg::ROW_BITS'(1);
            end
         end else begin
            col_in = col_ff + hpn_pkg::COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_vote_ff <= req_tdata[hpn_pkg::VOTE_BITS-1:0];
      end
   end

   assign up2 = rd_data[hpn_pkg::LINE_BITS-1:hpn_pkg::VOTE_BITS];
   assign up1 = rd_data[hpn_pkg::VOTE_BITS-1:0];

   hpn_line_ram u_line_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({up1, s1_vote_ff})
   );

   hpn_window u_window (
      .clock     (clock),
      .in_valid  (s1_valid_ff),
      .up2       (up2),
      .up1       (up1),
      .vote      (s1_vote_ff),
      .col       (s1_col_ff),
      .row       (s1_row_ff),
      .min_votes (min_votes_ff),
      .push      (push)
   );

   hpn_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .not_empty (rsp_tvalid),
      .count     (count),
      .head      (head)
   );

   assign rsp_tdata = {{(hpn_pkg::RSP_DATA_BITS - hpn_pkg::RSP_FIELD_BITS){1'b0}},
                       head.votes, head.theta, head.rho};

endmodule

FILE: hw/rtl/hpn_checker.sv
// ----------------------------------------------------------------------------
// hpn_checker
// Port-level checks of the Hough peak finder, bound to the top level.
// ----------------------------------------------------------------------------
module hpn_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [hpn_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [hpn_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input logic                                csr_wr_en,
   input logic [hpn_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input logic [hpn_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int THETA_LSB = hpn_pkg::ROW_BITS;
   localparam int THETA_MSB = hpn_pkg::ROW_BITS + hpn_pkg::COL_BITS - 1;

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Peaks are never on the first row or column.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[hpn_pkg::ROW_BITS-1:0] != '0) &&
                     (rsp_tdata[THETA_MSB:THETA_LSB] != '0))
      else $error("peak reported on a border");

   // The queue is empty right after reset.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("response pending after reset");

   // A new response follows an accepted request that passed the s1 stage and the queue.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without a matching request");

endmodule

bind hough_peak_nms_3x3 hpn_checker u_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the 3x3 Hough peak suppressor.
// ----------------------------------------------------------------------------
// Vote counts go in through the request stream and are mirrored in a local
// window and line store model, which predicts every peak that should come out
// of the response stream. A random phase comes first, then a short table of
// hand-checked accumulators. More random phases follow under several sizes and
// thresholds, including out-of-range sizes and a write to an unmapped register.
// Both streams idle and stall at random in most phases.
module tb;

   localparam logic [hpn_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 2'd3;
   localparam int SETTLE_CYCLES = 10;

   typedef struct {
      logic [hpn_pkg::VOTE_BITS-1:0] vote;
      bit                            hit;
      logic [hpn_pkg::ROW_BITS-1:0]  rho;
      logic [hpn_pkg::COL_BITS-1:0]  theta;
      logic [hpn_pkg::VOTE_BITS-1:0] votes;
   } dir_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [hpn_pkg::REQ_DATA_BITS-1:0]   req_tdata;   // [15:0] vote_count
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [hpn_pkg::RSP_DATA_BITS-1:0]   rsp_tdata;   // [11:0] rho, [21:12] theta, [37:22] votes
   logic                                csr_wr_en;
   logic [hpn_pkg::CSR_INDEX_BITS-1:0]  csr_index;
   logic [hpn_pkg::CSR_DATA_BITS-1:0]   csr_wdata;

   logic [hpn_pkg::VOTE_BITS-1:0]      line_two_up [hpn_pkg::MAX_THETA_BINS];
   logic [hpn_pkg::VOTE_BITS-1:0]      line_one_up [hpn_pkg::MAX_THETA_BINS];
   logic [hpn_pkg::VOTE_BITS-1:0]      win [3][3];
   int unsigned                        col_pos;
   int unsigned                        row_pos;
   logic [hpn_pkg::THETA_REG_BITS-1:0] theta_cfg;
   logic [hpn_pkg::RHO_REG_BITS-1:0]   rho_cfg;
   logic [hpn_pkg::VOTE_BITS-1:0]      min_votes_cfg;

   hpn_pkg::peak_type pending_peaks[$];
   int                error_count;
   bit                gaps_on;
   int                stall_left;

   // Three 3x3 accumulators: all maximal, a tie at exactly the threshold, and
   // a center one below the threshold.
   dir_row_type directed_rows [27] = '{
      '{16'hFFFF, 1'b0, 12'd0, 10'd0, 16'd0},
      '{16'hFFFF, 1'b0, 12'd0, 10'd0, 16'd0},
      '{16'hFFFF, 1'b0, 12'd0, 10'd0, 16'd0},
      '{16'hFFFF, 1'b0, 12'd0, 10'd0, 16'd0},
      '{16'hFFFF, 1'b0, 12'd0, 10'd0, 16'd0},
      '{16'hFFFF, 1'b0, 12'd0, 10'd0, 16'd0},
      '{16'hFFFF, 1'b0, 12'd0, 10'd0, 16'd0},
      '{16'hFFFF, 1'b0, 12'd0, 10'd0, 16'd0},
      '{16'hFFFF, 1'b1, 12'd1, 10'd1, 16'hFFFF},
      '{16'd100,  1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd0,    1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd0,    1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd0,    1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd100,  1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd0,    1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd0,    1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd0,    1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd0,    1'b1, 12'd1, 10'd1, 16'd100},
      '{16'd0,    1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd0,    1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd0,    1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd0,    1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd99,   1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd0,    1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd0,    1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd0,    1'b0, 12'd0, 10'd0, 16'd0},
      '{16'd0,    1'b0, 12'd0, 10'd0, 16'd0}
   };

   hough_peak_nms_3x3 u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int unsigned clamp_bins(int unsigned v, int unsigned hi);
      if (v < hpn_pkg::MIN_BINS) return hpn_pkg::MIN_BINS;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [hpn_pkg::VOTE_BITS-1:0] random_vote();
      int t;
      unique case ($urandom_range(0, 9))
         0, 1, 2, 3: return hpn_pkg::VOTE_BITS'($urandom_range(0, 65535));
         4, 5: return hpn_pkg::VOTE_BITS'($urandom_range(0, 3));
         6, 7: begin
            t = int'(min_votes_cfg) + int'($urandom_range(0, 4)) - 2;
            if (t < 0) t = 0;
            if (t > 65535) t = 65535;
            return hpn_pkg::VOTE_BITS'(t);
         end
         8: return '1;
         default: return '0;
      endcase
   endfunction

   task automatic apply_reg(input logic [hpn_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [hpn_pkg::CSR_DATA_BITS-1:0] data);
      unique case (idx)
         hpn_pkg::CSR_THETA_BINS: begin
            theta_cfg = data[hpn_pkg::THETA_REG_BITS-1:0];
            col_pos = 0;
            row_pos = 0;
         end
         hpn_pkg::CSR_RHO_BINS: begin
            rho_cfg = hpn_pkg::RHO_REG_BITS'(data);
            col_pos = 0;
            row_pos = 0;
         end
         hpn_pkg::CSR_MIN_VOTES: min_votes_cfg = data;
         default: ;
      endcase
   endtask

   task automatic predict_peak(input logic [hpn_pkg::VOTE_BITS-1:0] vote, output bit hit,
                               output hpn_pkg::peak_type peak);
      int unsigned n_theta;
      int unsigned n_rho;
      int unsigned ci;
      logic [hpn_pkg::VOTE_BITS-1:0] center;
      n_theta = clamp_bins(theta_cfg, hpn_pkg::MAX_THETA_BINS);
      n_rho = clamp_bins(rho_cfg, hpn_pkg::MAX_RHO_BINS);
      ci = (col_pos < hpn_pkg::MAX_THETA_BINS) ? col_pos : 0;
      hit = 1'b0;
      peak = '0;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = line_two_up[ci];
      win[1][2] = line_one_up[ci];
      win[2][2] = vote;
      line_two_up[ci] = line_one_up[ci];
      line_one_up[ci] = vote;
      if (row_pos >= 2 && col_pos >= 2) begin
         center = win[1][1];
         hit = (center >= min_votes_cfg);
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               if (!(i == 1 && j == 1) && win[i][j] > center) hit = 1'b0;
         if (hit) begin
            peak.rho = hpn_pkg::ROW_BITS'(row_pos - 1);
            peak.theta = hpn_pkg::COL_BITS'(col_pos - 1);
            peak.votes = center;
         end
      end
      if (col_pos + 1 >= n_theta) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= n_rho) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   // Entered and left at a falling edge; the valid is left high for the next
   // request unless that one starts with a gap.
   task automatic send_vote(input logic [hpn_pkg::VOTE_BITS-1:0] vote, input bit typed,
                            input bit typed_hit, input hpn_pkg::peak_type typed_peak);
      int gap;
      bit hit;
      hpn_pkg::peak_type peak;
      gap = gaps_on ? idle_len() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= hpn_pkg::REQ_DATA_BITS'(vote);
      do @(posedge clock); while (!req_tready);
      predict_peak(vote, hit, peak);
      if (typed) begin
         hit = typed_hit;
         peak = typed_peak;
      end
      if (hit) pending_peaks.insert(pending_peaks.size(), peak);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_vote(random_vote(), 1'b0, 1'b0, '0);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_reg(input logic [hpn_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [hpn_pkg::CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic settle();
      while (pending_peaks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_sizes(input logic [hpn_pkg::CSR_DATA_BITS-1:0] theta,
                              input logic [hpn_pkg::CSR_DATA_BITS-1:0] rho,
                              input logic [hpn_pkg::CSR_DATA_BITS-1:0] votes);
      write_reg(hpn_pkg::CSR_THETA_BINS, theta);
      write_reg(hpn_pkg::CSR_RHO_BINS, rho);
      write_reg(hpn_pkg::CSR_MIN_VOTES, votes);
      csr_wr_en <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (!gaps_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         stall_left = idle_len();
         rsp_tready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      hpn_pkg::peak_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_peaks.size() == 0) begin
            $error("unexpected peak: rho %0d theta %0d votes %0d",
                   rsp_tdata[11:0], rsp_tdata[21:12], rsp_tdata[37:22]);
            error_count++;
         end else begin
            want = pending_peaks.pop_front();
            if (rsp_tdata[11:0] !== want.rho) begin
               $error("peak_rho_index: expected %0d, actual %0d", want.rho, rsp_tdata[11:0]);
               error_count++;
            end
            if (rsp_tdata[21:12] !== want.theta) begin
               $error("peak_theta_index: expected %0d, actual %0d",
                      want.theta, rsp_tdata[21:12]);
               error_count++;
            end
            if (rsp_tdata[37:22] !== want.votes) begin
               $error("peak_votes: expected %0d, actual %0d", want.votes, rsp_tdata[37:22]);
               error_count++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_index = hpn_pkg::CSR_THETA_BINS;
      csr_wdata = '0;
      gaps_on = 1'b0;
      theta_cfg = hpn_pkg::THETA_RESET;
      rho_cfg = hpn_pkg::RHO_RESET;
      min_votes_cfg = hpn_pkg::VOTES_RESET;
      col_pos = 0;
      row_pos = 0;
      for (int i = 0; i < hpn_pkg::MAX_THETA_BINS; i++) begin
         line_two_up[i] = '0;
         line_one_up[i] = '0;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) win[i][j] = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      gaps_on = 1'b1;
      send_random(370);
      settle();

      gaps_on = 1'b0;
      write_sizes(16'd3, 16'd3, 16'd100);
      foreach (directed_rows[k])
         send_vote(directed_rows[k].vote, 1'b1, directed_rows[k].hit,
                   '{rho: directed_rows[k].rho, theta: directed_rows[k].theta,
                     votes: directed_rows[k].votes});
      req_tvalid <= 1'b0;
      settle();

      gaps_on = 1'b1;
      write_sizes(16'd0, 16'd2, 16'd0);
      send_random(90);
      settle();

      gaps_on = 1'b0;
      write_reg(CSR_UNMAPPED, 16'h0005);
      write_sizes(16'd4, 16'd4, 16'hFFFF);
      send_random(64);
      settle();

      gaps_on = 1'b1;
      write_sizes(16'hFFFF, 16'hFFFF, 16'd50);
      send_random(300);
      settle();

      write_sizes(16'd5, 16'd4, 16'd1000);
      send_random(150);
      settle();
      write_reg(hpn_pkg::CSR_MIN_VOTES, hpn_pkg::CSR_DATA_BITS'($urandom_range(0, 65535)));
      csr_wr_en <= 1'b0;
      send_random(150);
      settle();

      write_sizes(16'd17, 16'd6, hpn_pkg::CSR_DATA_BITS'($urandom_range(0, 65535)));
      send_random(250);
      settle();

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: hough_peak_nms_3x3.f
hw/rtl/hpn_pkg.sv
hw/rtl/hpn_line_ram.sv
hw/rtl/hpn_window.sv
hw/rtl/hpn_out_queue.sv
hw/rtl/hough_peak_nms_3x3.sv
hw/rtl/hpn_checker.sv
test/tb.sv
